// ===== src/comap_pkg.sv =====
// Package: types, constants and codes for the code offset to source map unit.
`timescale 1ns / 1ps
package comap_pkg;
  localparam int TableEntries = 1024;
  localparam int IdxW = $clog2(TableEntries);
  localparam int CntW = IdxW + 1;
  localparam logic [31:0] MissValue = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD = 2'd1;
  localparam logic [1:0] ACT_FINAL = 2'd2;
  localparam logic [1:0] ACT_XLATE = 2'd3;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_HIT = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam logic [1:0] REG_CBASE = 2'd0;
  localparam logic [1:0] REG_SRC_BASE = 2'd1;
  localparam logic [1:0] REG_CEND = 2'd2;
  localparam logic [1:0] REG_LOOKUP = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [63:0] insn_addr;
    logic [63:0] source_addr;
    logic [63:0] query_pc;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [31:0] source_offset;
  } rsp_t;
endpackage

// ===== src/comap_if.sv =====
// Interfaces: valid/ready channels for request and response items.
`timescale 1ns / 1ps
interface comap_req_if;
  logic valid;
  logic ready;
  comap_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface comap_rsp_if;
  logic valid;
  logic ready;
  comap_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/code_offset_to_source_map_unit.sv =====
// Top level: offset map table with insertion sort and binary search sequencer.
//
//  channel | dir | contents
//  req     | in  | action, insn_addr, source_addr, query_pc
//  rsp     | out | status, source_offset
//  cfg     | in  | cfg_we, cfg_index, cfg_data (4 x 64-bit registers)
//
// Clear and add go straight to the response; a translate hit runs a binary search,
// one table read per search step through a single registered read port.
// Finalize runs an insertion sort over the table entries.
// Reset is synchronous; the table contents need no clearing.
// The request side is not ready while an item is in work or its result waits.
`timescale 1ns / 1ps
module code_offset_to_source_map_unit (
  input logic clk,
  input logic rst,
  comap_req_if.sink req,
  comap_rsp_if.source rsp,
  input logic cfg_we,
  input logic [1:0] cfg_index,
  input logic [63:0] cfg_data
);
  import comap_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCHK = 4'd1;
  localparam logic [3:0] S_SRD = 4'd2;
  localparam logic [3:0] S_SKEY = 4'd3;
  localparam logic [3:0] S_SCMP = 4'd4;
  localparam logic [3:0] S_SPUT = 4'd5;
  localparam logic [3:0] S_FIRST = 4'd6;
  localparam logic [3:0] S_BCHK = 4'd7;
  localparam logic [3:0] S_BCMP = 4'd8;
  localparam logic [3:0] S_BFIN = 4'd9;
  localparam logic [3:0] S_RSP = 4'd10;
  localparam logic [3:0] S_SRDW = 4'd11;
  localparam logic [3:0] S_FWAIT = 4'd12;
  localparam logic [3:0] S_HRD = 4'd13;
  localparam logic [3:0] S_BSTEP = 4'd14;
  localparam logic [3:0] S_HIT = 4'd15;

  logic [63:0] cbase, src_base, cend, lk_base;
  logic [63:0] mem [TableEntries];
  logic [63:0] rd;
  logic [IdxW-1:0] ra;
  logic wen;
  logic [IdxW-1:0] wa;
  logic [63:0] wd;
  logic [CntW-1:0] count, i, j, lo, hi;
  logic ready_tbl;
  logic [3:0] state;
  logic [63:0] key, diff;
  rsp_t out;
  logic [CntW-1:0] mid;

  assign mid = lo + ((hi - lo) >> 1);
  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_RSP);
  assign rsp.data = out;

  always_ff @(posedge clk) begin
    if (wen) mem[wa] <= wd;
    rd <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cbase <= '0; src_base <= '0; cend <= '0; lk_base <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CBASE: cbase <= cfg_data;
        REG_SRC_BASE: src_base <= cfg_data;
        REG_CEND: cend <= cfg_data;
        REG_LOOKUP: lk_base <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [63:0] csize;
  always_comb begin
    if (cbase == '0 || cend == '0 || cend < cbase) csize = '0;
    else csize = cend - cbase;
  end

  always_ff @(posedge clk) begin
    if (rst) wen <= 1'b0;
    else wen <= (state == S_IDLE && req.valid && req.data.action == ACT_ADD &&
                 count < CntW'(TableEntries)) ||
                (state == S_BFIN && rd[31:0] > key[31:0]) ||
                (state == S_SPUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; count <= '0; ready_tbl <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (req.valid) begin
          case (req.data.action)
            ACT_CLEAR: begin
              out <= '{ST_DONE, 32'd0}; count <= '0; ready_tbl <= 1'b0; state <= S_RSP;
            end
            ACT_ADD: begin
              state <= S_RSP;
              if (count >= CntW'(TableEntries)) out <= '{ST_FULL, 32'd0};
              else begin
                out <= '{ST_DONE, 32'd0};
                wa <= count[IdxW-1:0];
                wd <= {32'(req.data.source_addr - src_base),
                       32'(req.data.insn_addr - cbase)};
                count <= count + 1'b1; ready_tbl <= 1'b0;
              end
            end
            ACT_FINAL: begin
              out <= '{ST_DONE, 32'd0}; ready_tbl <= 1'b1; i <= CntW'(1); state <= S_SCHK;
            end
            default: begin
              out <= '{ST_MISS, MissValue};
              diff <= req.data.query_pc - lk_base;
              if (ready_tbl && count != '0 && req.data.query_pc >= lk_base) begin
                ra <= '0; state <= S_FWAIT;
              end else state <= S_RSP;
            end
          endcase
        end
        S_SCHK: if (i >= count) state <= S_RSP;
          else begin ra <= i[IdxW-1:0]; j <= i; state <= S_SRDW; end
        S_SRDW: state <= S_SKEY;
        S_SKEY: begin key <= rd; state <= S_SRD; end
        S_SRD: if (j == '0) state <= S_SPUT;
          else begin ra <= IdxW'(j - 1'b1); state <= S_SCMP; end
        S_SCMP: state <= S_BFIN;
        S_BFIN: if (rd[31:0] > key[31:0]) begin
            wa <= j[IdxW-1:0]; wd <= rd; j <= j - 1'b1; state <= S_SRD;
          end else state <= S_SPUT;
        S_SPUT: begin
          wa <= j[IdxW-1:0]; wd <= key; i <= i + 1'b1; state <= S_SCHK;
        end
        S_FWAIT: state <= S_FIRST;
        S_FIRST: if (diff >= csize || diff < {32'd0, rd[31:0]}) state <= S_RSP;
          else begin lo <= '0; hi <= count; state <= S_BCHK; end
        S_BCHK: if (hi - lo > CntW'(1)) begin ra <= mid[IdxW-1:0]; state <= S_BCMP; end
          else begin ra <= lo[IdxW-1:0]; state <= S_HRD; end
        S_BCMP: state <= S_BSTEP;
        S_BSTEP: begin
          if (rd[31:0] <= diff[31:0]) lo <= mid; else hi <= mid;
          state <= S_BCHK;
        end
        S_HRD: state <= S_HIT;
        S_HIT: begin out <= '{ST_HIT, rd[63:32]}; state <= S_RSP; end
        S_RSP: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/comap_checker.sv =====
// Checker: port-level properties of the offset map unit, bound to the top level.
`timescale 1ns / 1ps
module comap_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic [1:0] rsp_status,
  input logic [31:0] rsp_offset
);
  import comap_pkg::*;
  a_excl: assert property (@(posedge clk) disable iff (rst) !(req_ready && rsp_valid))
    else $error("ready while result pending");
  a_miss: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_MISS |-> rsp_offset == MissValue)
    else $error("miss offset");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == ST_DONE || rsp_status == ST_FULL) |-> rsp_offset == '0)
    else $error("nonzero offset");
  a_take: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready after accept");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_offset))
    else $error("result changed while waiting");
endmodule

bind code_offset_to_source_map_unit comap_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.data.status), .rsp_offset(rsp.data.source_offset)
);
